### design/max_heap_priority_queue_top_macros.svh
// Assertion macros for the max-heap priority queue checker.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef MAX_HEAP_PRIORITY_QUEUE_TOP_MACROS_SVH
`define MAX_HEAP_PRIORITY_QUEUE_TOP_MACROS_SVH

// Check a property on every rising edge outside reset.
`define HPQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check an implication on every rising edge outside reset.
`define HPQ_ASSERT_IMPL(label, ante, cons, msg) \
  `HPQ_ASSERT(label, (ante) |-> (cons), msg)

// Check that a condition is followed by another in the next cycle.
`define HPQ_ASSERT_NEXT(label, ante, cons, msg) \
  `HPQ_ASSERT(label, (ante) |=> (cons), msg)

`endif

### design/hpq_pkg.sv
// Shared types for the max-heap priority queue.
// No dependencies; used by the cell, the top level and the interfaces' users.
package hpq_pkg;

  // Operation code carried in the op field of an input transaction
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  // Result status
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } hpq_status_e;

  // Per-cycle command broadcast to every cell of the row
  typedef struct packed {
    logic insert;
    logic remove;
  } hpq_cmd_t;

endpackage

### design/hpq_if.sv
// Valid/ready channel interfaces for the max-heap priority queue.
// No dependencies; widths follow the top level's parameters.
interface hpq_in_if #(
  parameter int KEY_WIDTH = 32
);
  logic                        valid;
  logic                        ready;
  logic                        op;
  logic signed [KEY_WIDTH-1:0] value;

  modport source (output valid, output op, output value, input ready);
  modport sink   (input valid, input op, input value, output ready);
endinterface

interface hpq_out_if #(
  parameter int KEY_WIDTH = 32,
  parameter int CNT_W     = 8
);
  logic                        valid;
  logic                        ready;
  logic signed [KEY_WIDTH-1:0] top_value;
  logic                        top_valid;
  logic [CNT_W-1:0]            entry_count;
  logic                        heap_full;
  logic [1:0]                  status;

  modport source (output valid, output top_value, output top_valid, output entry_count,
                  output heap_full, output status, input ready);
  modport sink   (input valid, input top_value, input top_valid, input entry_count,
                  input heap_full, input status, output ready);
endinterface

### design/max_heap_priority_queue_top.sv
// Max-heap priority queue kept as a row of sorted key cells, largest first.
// Result valid in the cycle after the input transaction is accepted.
// One transaction per cycle unless a result stalls; every cell does one
// compare and one shift per cycle, so the cell row sets the rate at any depth.
// Reset clears the fill count and the result register; keys are not cleared.
module max_heap_priority_queue_top
  import hpq_pkg::*;
#(
  parameter int HEAP_DEPTH = 128,
  parameter int KEY_WIDTH  = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  hpq_in_if.sink    in_i,
  hpq_out_if.source out_o
);

  localparam int              CNT_W   = $clog2(HEAP_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(HEAP_DEPTH);

  logic [CNT_W-1:0]            count_q, count_d;
  logic                        out_valid_q, out_valid_d;
  hpq_status_e                 status_q, status_d;
  hpq_cmd_t                    cmd;
  logic                        in_fire;
  logic                        full;
  logic                        empty;
  logic signed [KEY_WIDTH-1:0] key_row [HEAP_DEPTH];
  logic                        ge_row  [HEAP_DEPTH];

  assign full    = count_q == DEPTH_C;
  assign empty   = count_q == '0;
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_fire = in_i.valid && in_i.ready;

  // Decode the transaction; drop it when the heap is full or empty
  always_comb begin
    cmd.insert = in_fire && (in_i.op == OP_INSERT) && !full;
    cmd.remove = in_fire && (in_i.op == OP_REMOVE) && !empty;
  end

  // Advance the fill count and pick the status
  always_comb begin
    count_d  = count_q;
    status_d = status_q;
    if (in_fire) begin
      status_d = ST_OK;
      if (in_i.op == OP_INSERT) begin
        if (full) begin
          status_d = ST_OVERFLOW;
        end else begin
          count_d = count_q + CNT_W'(1);
        end
      end else begin
        if (empty) begin
          status_d = ST_UNDERFLOW;
        end else begin
          count_d = count_q - CNT_W'(1);
        end
      end
    end
  end

  // Hold the result until the sink takes it
  always_comb begin
    out_valid_d = out_valid_q;
    if (in_fire) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
      status_q    <= ST_OK;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      status_q    <= status_d;
    end
  end

  // Row of key cells, cell 0 holds the maximum
  for (genvar i = 0; i < HEAP_DEPTH; i++) begin : g_cell
    logic signed [KEY_WIDTH-1:0] prev_key;
    logic                        prev_ge;
    logic signed [KEY_WIDTH-1:0] next_key;

    if (i == 0) begin : g_first
      assign prev_key = key_row[0];
      assign prev_ge  = 1'b1;
    end else begin : g_mid
      assign prev_key = key_row[i-1];
      assign prev_ge  = ge_row[i-1];
    end

    if (i == HEAP_DEPTH - 1) begin : g_last
      assign next_key = key_row[i];
    end else begin : g_body
      assign next_key = key_row[i+1];
    end

    hpq_cell #(
      .KEY_WIDTH (KEY_WIDTH),
      .CNT_W     (CNT_W),
      .IDX       (i)
    ) u_cell (
      .clk_i      (clk_i),
      .cmd_i      (cmd),
      .count_i    (count_q),
      .ins_key_i  (in_i.value),
      .prev_key_i (prev_key),
      .prev_ge_i  (prev_ge),
      .next_key_i (next_key),
      .key_o      (key_row[i]),
      .ge_o       (ge_row[i])
    );
  end

  // Drive the result from the state left by the last transaction
  assign out_o.valid       = out_valid_q;
  assign out_o.top_valid   = !empty;
  assign out_o.top_value   = empty ? '0 : key_row[0];
  assign out_o.entry_count = count_q;
  assign out_o.heap_full   = full;
  assign out_o.status      = status_q;

endmodule

### design/hpq_cell.sv
// One slot of the sorted key row: holds a key, compares it with the
// inserted key and shifts with its neighbors. Depends on hpq_pkg.
module hpq_cell
  import hpq_pkg::*;
#(
  parameter int KEY_WIDTH = 32,
  parameter int CNT_W     = 8,
  parameter int IDX       = 0
) (
  input  logic                        clk_i,
  input  hpq_cmd_t                    cmd_i,
  input  logic [CNT_W-1:0]            count_i,
  input  logic signed [KEY_WIDTH-1:0] ins_key_i,
  input  logic signed [KEY_WIDTH-1:0] prev_key_i,
  input  logic                        prev_ge_i,
  input  logic signed [KEY_WIDTH-1:0] next_key_i,
  output logic signed [KEY_WIDTH-1:0] key_o,
  output logic                        ge_o
);

  logic signed [KEY_WIDTH-1:0] key_q, key_d;
  logic                        occ;

  // Slot holds a live key when it lies below the fill count
  assign occ  = count_i > CNT_W'(IDX);
  // Keep the own key when it is not smaller than the inserted key
  assign ge_o = occ && !(ins_key_i > key_q);

  // Select: hold, take the new key, shift down on insert, shift up on remove
  always_comb begin
    key_d = key_q;
    if (cmd_i.insert) begin
      if (ge_o) begin
        key_d = key_q;
      end else if (prev_ge_i) begin
        key_d = ins_key_i;
      end else begin
        key_d = prev_key_i;
      end
    end else if (cmd_i.remove) begin
      key_d = next_key_i;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

  assign key_o = key_q;

endmodule

### design/hpq_checker.sv
// Port-level checks for the max-heap priority queue, bound to the top level.
// Depends on max_heap_priority_queue_top_macros.svh.
`include "max_heap_priority_queue_top_macros.svh"

module hpq_checker #(
  parameter int HEAP_DEPTH = 128,
  parameter int KEY_WIDTH  = 32
) (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 in_valid_i,
  input logic                                 in_ready_i,
  input logic                                 out_valid_i,
  input logic                                 out_ready_i,
  input logic signed [KEY_WIDTH-1:0]          top_value_i,
  input logic                                 top_valid_i,
  input logic [$clog2(HEAP_DEPTH + 1)-1:0]    entry_count_i,
  input logic                                 heap_full_i
);

  localparam int              CNT_W   = $clog2(HEAP_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(HEAP_DEPTH);

  // Count stays within capacity
  `HPQ_ASSERT(a_count_range, entry_count_i <= DEPTH_C, "entry count above capacity")

  // Full flag tracks the count
  `HPQ_ASSERT(a_full_flag, heap_full_i == (entry_count_i == DEPTH_C), "full flag mismatch")

  // An empty heap shows no valid top and a zero value
  `HPQ_ASSERT_IMPL(a_empty_top, out_valid_i && !top_valid_i,
                   (entry_count_i == '0) && (top_value_i == '0), "empty heap shows a top")

  // An accepted transaction yields a result in the next cycle
  `HPQ_ASSERT_NEXT(a_result_next, in_valid_i && in_ready_i, out_valid_i,
                   "no result after an accepted transaction")

  // A pending result blocks input until it is taken
  `HPQ_ASSERT_IMPL(a_stall_in, out_valid_i && !out_ready_i, !in_ready_i,
                   "input accepted while the result is stalled")

endmodule

bind max_heap_priority_queue_top hpq_checker #(
  .HEAP_DEPTH (HEAP_DEPTH),
  .KEY_WIDTH  (KEY_WIDTH)
) u_hpq_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .top_value_i   (out_o.top_value),
  .top_valid_i   (out_o.top_valid),
  .entry_count_i (out_o.entry_count),
  .heap_full_i   (out_o.heap_full)
);
